[src/expression_tokenizer_assert.svh]
// Assertion macros for the checker file of the tokenizer.
`ifndef EXPRESSION_TOKENIZER_ASSERT_SVH
`define EXPRESSION_TOKENIZER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ET_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/et_pkg.sv]
`timescale 1ns / 1ps

package et_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_IDENT_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Field and bus widths.
    localparam int CHAR_W      = 8;
    localparam int TYPE_W      = 3;
    localparam int TOKVAL_W    = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;
    localparam int PAD_W       = OUT_TDATA_W - TOKVAL_W - 3 * CHAR_W - 1;

    // Keyword lengths.
    localparam int KW_TRUE_LEN  = 4;
    localparam int KW_FALSE_LEN = 5;

    // Token kinds as seen on the output tuser.
    typedef enum logic [TYPE_W-1:0] {
        TOK_INT    = 3'd0,
        TOK_IDENT  = 3'd1,
        TOK_BOOL   = 3'd2,
        TOK_OP     = 3'd3,
        TOK_LPAREN = 3'd4,
        TOK_RPAREN = 3'd5,
        TOK_END    = 3'd6,
        TOK_ERR    = 3'd7
    } t_tok;

    // Kind of token currently being collected.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_OP    = 2'd3
    } t_mode;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_EOF    = 8'hFF;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_DIG0   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIG9   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the incoming character
        logic num;      // fold a digit into the number accumulator
        logic append;   // append a character to the identifier buffer
        logic rd_init;  // rewind the identifier read pointer
        logic flush;    // emit the pending number, boolean or operator
        logic start;    // handle the character as the start of a token
        logic drain;    // emit one buffered identifier character
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;
        logic  halted;
        logic  is_dig;
        logic  is_letdig;
        logic  is_eq;
        logic  emits;      // the character produces a token of its own
        logic  is_bool;    // buffered identifier is a boolean keyword
        logic  slot_free;  // output register can take a token this cycle
        logic  drain_last; // read pointer is at the last buffered character
    } t_dp_stat;

    function automatic logic f_is_dig(input logic [CHAR_W-1:0] c);
        return (c >= CH_DIG0) && (c <= CH_DIG9);
    endfunction

    function automatic logic f_is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
               ((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic f_is_op(input logic [CHAR_W-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_EQ) || (c == CH_BANG) ||
               (c == CH_LT) || (c == CH_GT);
    endfunction

    // Character of "true" at a given position.
    function automatic logic [CHAR_W-1:0] f_true_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h74;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h65;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Character of "false" at a given position.
    function automatic logic [CHAR_W-1:0] f_false_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h66;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h6C;
            3'd3:    ch = 8'h73;
            3'd4:    ch = 8'h65;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

[src/expression_tokenizer.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake                          Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata[7:0] src_char
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: value, ident, ops, trunc;
//                                                   tuser: token_type; tlast: last
//
// A character is accepted in S_IDLE and evaluated in S_EVAL. Emitting a pending number,
// boolean or operator adds S_FLUSH and S_START; an '=' ending an operator skips S_START.
// Closing an identifier drains the buffer through S_RD and S_DRAIN per character, then
// S_START takes the closing character. A stalled output holds the current step, while one
// finished token waits in the output register as the next character is accepted.
// Reset is synchronous and active low and clears the lexer control state.

module expression_tokenizer #(
    parameter int MAX_IDENT   = et_pkg::MAX_IDENT_DEF,
    parameter int VALUE_WIDTH = et_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [7:0] src_char
    input  logic [et_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] token_value, [39:32] ident_char, [47:40] op_first,
    // [55:48] op_second, [56] truncated, [63:57] zero
    output logic [et_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] token_type
    output logic [et_pkg::TYPE_W-1:0]      o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import et_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer for the steps of one character.
    et_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    // Lexer state, identifier buffer and output register.
    et_dp #(
        .MAX_IDENT   (MAX_IDENT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

[src/et_dp.sv]
`timescale 1ns / 1ps

module et_dp #(
    parameter int MAX_IDENT   = et_pkg::MAX_IDENT_DEF,
    parameter int VALUE_WIDTH = et_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [et_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  et_pkg::t_dp_cmd                i_cmd,
    output et_pkg::t_dp_stat               o_stat,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [et_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [et_pkg::TYPE_W-1:0]      o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import et_pkg::*;

    localparam int LEN_W = $clog2(MAX_IDENT + 1);
    localparam int IDX_W = $clog2(MAX_IDENT);

    // Lexer state.
    logic [CHAR_W-1:0]      r_char;
    t_mode                  r_mode;
    logic [VALUE_WIDTH-1:0] r_accum;
    logic [LEN_W-1:0]       r_len;
    logic                   r_ovf;
    logic                   r_tpre;
    logic                   r_fpre;
    logic [CHAR_W-1:0]      r_op;
    logic                   r_halted;

    // Identifier buffer and its read side.
    logic [CHAR_W-1:0]      r_mem [MAX_IDENT];
    logic [IDX_W-1:0]       r_rd_idx;
    logic [CHAR_W-1:0]      r_rd_data;

    // Output register.
    logic                   r_oval;
    t_tok                   r_otype;
    logic [TOKVAL_W-1:0]    r_oval_data;
    logic [CHAR_W-1:0]      r_ichar;
    logic [CHAR_W-1:0]      r_o1;
    logic [CHAR_W-1:0]      r_o2;
    logic                   r_trunc;
    logic                   r_olast;

    // Classification of the latched character.
    logic c_dig, c_let, c_op, c_space, c_end, c_lp, c_rp, c_err, c_emits, c_eq;
    logic slot_free, is_bool, drain_last, can_append;
    logic [VALUE_WIDTH-1:0] n_accum;

    assign c_dig   = f_is_dig(r_char);
    assign c_let   = f_is_letter(r_char);
    assign c_op    = f_is_op(r_char);
    assign c_space = (r_char == CH_SPACE);
    assign c_end   = (r_char == CH_NUL) || (r_char == CH_EOF);
    assign c_lp    = (r_char == CH_LPAREN);
    assign c_rp    = (r_char == CH_RPAREN);
    assign c_eq    = (r_char == CH_EQ);
    assign c_err   = !(c_dig || c_let || c_op || c_space || c_end || c_lp || c_rp);
    assign c_emits = c_end || c_lp || c_rp || c_err;

    assign slot_free  = !r_oval || i_m_axis_tready;
    assign can_append = (r_len < LEN_W'(MAX_IDENT));
    assign is_bool    = !r_ovf &&
                        ((r_tpre && (r_len == LEN_W'(KW_TRUE_LEN))) ||
                         (r_fpre && (r_len == LEN_W'(KW_FALSE_LEN))));
    assign drain_last = ((LEN_W'(r_rd_idx) + LEN_W'(1)) == r_len);

    // Decimal accumulate: times ten as two shifts and an add.
    assign n_accum = (r_accum << 3) + (r_accum << 1) + VALUE_WIDTH'(r_char[3:0]);

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.halted     = r_halted;
        o_stat.is_dig     = c_dig;
        o_stat.is_letdig  = c_dig || c_let;
        o_stat.is_eq      = c_eq;
        o_stat.emits      = c_emits;
        o_stat.is_bool    = is_bool;
        o_stat.slot_free  = slot_free;
        o_stat.drain_last = drain_last;
    end

    // Latched character.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_s_axis_tdata[CHAR_W-1:0];
        end
    end

    // Identifier buffer: one write port, registered read at the drain pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && can_append) begin
            r_mem[r_len[IDX_W-1:0]] <= r_char;
        end else if (i_cmd.start && c_let) begin
            r_mem[0] <= r_char;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // Lexer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_accum  <= '0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_tpre   <= 1'b0;
            r_fpre   <= 1'b0;
            r_op     <= '0;
            r_halted <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.num) begin
                r_accum <= n_accum;
            end
            if (i_cmd.append) begin
                if (can_append) begin
                    r_len  <= r_len + LEN_W'(1);
                    r_tpre <= r_tpre && (r_len < LEN_W'(KW_TRUE_LEN)) &&
                              (r_char == f_true_char(r_len[2:0]));
                    r_fpre <= r_fpre && (r_len < LEN_W'(KW_FALSE_LEN)) &&
                              (r_char == f_false_char(r_len[2:0]));
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.rd_init) begin
                r_rd_idx <= '0;
            end
            // Emitting a pending token returns to idle.
            if (i_cmd.flush) begin
                r_mode  <= MODE_IDLE;
                r_accum <= '0;
                r_op    <= '0;
                r_len   <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.drain) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
                if (drain_last) begin
                    r_mode <= MODE_IDLE;
                    r_len  <= '0;
                    r_ovf  <= 1'b0;
                end
            end
            if (i_cmd.start) begin
                if (c_end) begin
                    r_mode  <= MODE_IDLE;
                    r_accum <= '0;
                    r_len   <= '0;
                    r_ovf   <= 1'b0;
                    r_op    <= '0;
                end else if (c_dig) begin
                    r_mode  <= MODE_NUM;
                    r_accum <= VALUE_WIDTH'(r_char[3:0]);
                end else if (c_let) begin
                    r_mode <= MODE_IDENT;
                    r_len  <= LEN_W'(1);
                    r_ovf  <= 1'b0;
                    r_tpre <= (r_char == f_true_char(3'd0));
                    r_fpre <= (r_char == f_false_char(3'd0));
                end else if (c_op) begin
                    r_mode <= MODE_OP;
                    r_op   <= r_char;
                end else if (c_err) begin
                    r_halted <= 1'b1;
                end
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.flush || i_cmd.drain || (i_cmd.start && c_emits)) begin
            r_oval <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    // Output payload, loaded from the source the controller selects.
    always_ff @(posedge i_clk) begin
        if (i_cmd.flush) begin
            r_oval_data <= '0;
            r_ichar     <= '0;
            r_o1        <= '0;
            r_o2        <= '0;
            r_trunc     <= 1'b0;
            r_olast     <= !c_emits || ((r_mode == MODE_OP) && c_eq);
            if (r_mode == MODE_NUM) begin
                r_otype     <= TOK_INT;
                r_oval_data <= TOKVAL_W'(r_accum);
            end else if (r_mode == MODE_IDENT) begin
                r_otype     <= TOK_BOOL;
                r_oval_data <= TOKVAL_W'(r_tpre);
            end else begin
                r_otype <= TOK_OP;
                r_o1    <= r_op;
                r_o2    <= c_eq ? CH_EQ : CH_NUL;
            end
        end else if (i_cmd.drain) begin
            r_otype     <= TOK_IDENT;
            r_oval_data <= '0;
            r_ichar     <= r_rd_data;
            r_o1        <= '0;
            r_o2        <= '0;
            r_trunc     <= r_ovf;
            r_olast     <= drain_last && !c_emits;
        end else if (i_cmd.start && c_emits) begin
            r_oval_data <= '0;
            r_ichar     <= '0;
            r_o1        <= '0;
            r_o2        <= '0;
            r_trunc     <= 1'b0;
            r_olast     <= 1'b1;
            if (c_end) begin
                r_otype <= TOK_END;
            end else if (c_lp) begin
                r_otype <= TOK_LPAREN;
            end else if (c_rp) begin
                r_otype <= TOK_RPAREN;
            end else begin
                r_otype <= TOK_ERR;
            end
        end
    end

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata  = {PAD_W'(0), r_trunc, r_o2, r_o1, r_ichar, r_oval_data};
    assign o_m_axis_tuser  = r_otype;
    assign o_m_axis_tlast  = r_olast;

endmodule

[src/et_ctrl.sv]
`timescale 1ns / 1ps

module et_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  et_pkg::t_dp_stat i_stat,
    output et_pkg::t_dp_cmd  o_cmd
);
    import et_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_FLUSH = 6'b000100,
        S_START = 6'b001000,
        S_RD    = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   start_ok;

    // A character with no token of its own never waits for the output register.
    assign start_ok = i_stat.slot_free || !i_stat.emits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                // After an error token every transaction is dropped.
                if (i_s_axis_tvalid && !i_stat.halted) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                unique case (i_stat.mode)
                    MODE_NUM: begin
                        if (i_stat.is_dig) begin
                            o_cmd.num = 1'b1;
                            n_state   = S_IDLE;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end
                    MODE_IDENT: begin
                        if (i_stat.is_letdig) begin
                            o_cmd.append = 1'b1;
                            n_state      = S_IDLE;
                        end else if (i_stat.is_bool) begin
                            n_state = S_FLUSH;
                        end else begin
                            o_cmd.rd_init = 1'b1;
                            n_state       = S_RD;
                        end
                    end
                    MODE_OP: begin
                        n_state = S_FLUSH;
                    end
                    default: begin
                        if (start_ok) begin
                            o_cmd.start = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                endcase
            end
            S_FLUSH: begin
                if (i_stat.slot_free) begin
                    o_cmd.flush = 1'b1;
                    // An '=' completing an operator is consumed by it.
                    if ((i_stat.mode == MODE_OP) && i_stat.is_eq) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (start_ok) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_stat.slot_free) begin
                    o_cmd.drain = 1'b1;
                    n_state     = i_stat.drain_last ? S_START : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

endmodule

[src/et_chk.sv]
`timescale 1ns / 1ps
`include "expression_tokenizer_assert.svh"

module et_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [et_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [et_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [et_pkg::TYPE_W-1:0]      o_m_axis_tuser,
    input logic                           o_m_axis_tlast
);
    import et_pkg::*;

    logic m_stall;
    logic m_err_taken;
    logic m_closing;

    assign m_stall     = o_m_axis_tvalid && !i_m_axis_tready;
    assign m_err_taken = o_m_axis_tvalid && i_m_axis_tready && (o_m_axis_tuser == TOK_ERR);
    assign m_closing   = o_m_axis_tvalid &&
                         ((o_m_axis_tuser == TOK_END) || (o_m_axis_tuser == TOK_ERR));

    // A stalled token keeps its payload.
    `ET_ASSERT_NEXT(a_stall_hold, m_stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
        $stable(o_m_axis_tlast), "stalled output transaction changed")

    // End and error tokens always close their character's results.
    `ET_ASSERT_SAME(a_closing_last, m_closing, o_m_axis_tlast,
        "end or error token without last")

    // Once an error token is taken nothing more is produced.
    `ET_ASSERT_NEXT(a_err_silent, m_err_taken, !o_m_axis_tvalid,
        "output after error token")

    // The truncation flag only accompanies identifier characters.
    `ET_ASSERT_SAME(a_trunc_ident, o_m_axis_tvalid && o_m_axis_tdata[56],
        o_m_axis_tuser == TOK_IDENT, "truncated flag on non-identifier token")

endmodule

bind expression_tokenizer et_chk u_et_chk (.*);
